FILE: rtl/mps_pkg.sv
// Shared widths, codes and types for the Moran process step block.
package mps_pkg;

    localparam int MAX_POPULATION_DEF = 128;
    localparam int FITNESS_BITS_DEF   = 10;
    localparam int MAX_TYPES_DEF      = 256;

    localparam int OP_W       = 2;
    localparam int ENTRY_W    = 7;
    localparam int FIT_IN_W   = 10;
    localparam int TYPE_IN_W  = 8;
    localparam int DRAW_W     = 14;
    localparam int STATUS_W   = 2;
    localparam int CNT_OUT_W  = 8;
    localparam int POP_SIZE_W = 8;

    localparam int DRAW_SCALE = 10000;
    localparam logic [DRAW_W-1:0]     DRAW_MAX       = 14'd9999;
    localparam logic [POP_SIZE_W-1:0] POP_SIZE_RESET = 8'd100;

    localparam logic [OP_W-1:0] OP_CLEAR = 2'd0;
    localparam logic [OP_W-1:0] OP_LOAD  = 2'd1;
    localparam logic [OP_W-1:0] OP_STEP  = 2'd2;

    localparam logic [STATUS_W-1:0] ST_OK           = 2'd0;
    localparam logic [STATUS_W-1:0] ST_BAD_INDEX    = 2'd1;
    localparam logic [STATUS_W-1:0] ST_ZERO_FITNESS = 2'd2;
    localparam logic [STATUS_W-1:0] ST_NO_TYPE_ID   = 2'd3;

    typedef struct packed {
        logic clr;
        logic en;
        logic scaled;
    } walk_ctl_t;

endpackage

FILE: rtl/mps_in_if.sv
// Input item channel of the Moran process step block.
interface mps_in_if
    import mps_pkg::*;
();
    logic                 valid;
    logic                 ready;
    logic [OP_W-1:0]      operation;
    logic [ENTRY_W-1:0]   entry_index;
    logic [FIT_IN_W-1:0]  fitness_value;
    logic [TYPE_IN_W-1:0] type_value;
    logic [DRAW_W-1:0]    birth_draw;
    logic [DRAW_W-1:0]    mutation_draw;

    modport source (
        output valid, operation, entry_index, fitness_value, type_value,
               birth_draw, mutation_draw,
        input  ready
    );

    modport sink (
        input  valid, operation, entry_index, fitness_value, type_value,
               birth_draw, mutation_draw,
        output ready
    );
endinterface

FILE: rtl/mps_out_if.sv
// Result channel of the Moran process step block.
interface mps_out_if
    import mps_pkg::*;
();
    logic                 valid;
    logic                 ready;
    logic [STATUS_W-1:0]  status;
    logic [ENTRY_W-1:0]   victim_index;
    logic [ENTRY_W-1:0]   parent_index;
    logic                 mutated;
    logic [TYPE_IN_W-1:0] written_type;
    logic [CNT_OUT_W-1:0] written_type_count;
    logic                 fixed;

    modport source (
        output valid, status, victim_index, parent_index, mutated, written_type,
               written_type_count, fixed,
        input  ready
    );

    modport sink (
        input  valid, status, victim_index, parent_index, mutated, written_type,
               written_type_count, fixed,
        output ready
    );
endinterface

FILE: rtl/mps_cfg_if.sv
// Configuration write channel of the Moran process step block.
interface mps_cfg_if
    import mps_pkg::*;
();
    logic                  valid;
    logic                  ready;
    logic [POP_SIZE_W-1:0] population_size;

    modport source (
        output valid, population_size,
        input  ready
    );

    modport sink (
        input  valid, population_size,
        output ready
    );
endinterface

FILE: rtl/mps_walk.sv
// Shared accumulate-and-compare unit used by the fitness sum and roulette passes.
module mps_walk
    import mps_pkg::*;
#(
    parameter int MAX_POPULATION = MAX_POPULATION_DEF,
    parameter int FITNESS_BITS   = FITNESS_BITS_DEF
)(
    input  logic                 clk,
    input  walk_ctl_t            ctl,
    input  logic [FITNESS_BITS-1:0] fit,
    input  logic [FITNESS_BITS + ((MAX_POPULATION > 1) ? $clog2(MAX_POPULATION) : 1)
                  + DRAW_W - 1:0] limit,
    output logic [FITNESS_BITS + ((MAX_POPULATION > 1) ? $clog2(MAX_POPULATION) : 1)
                  + DRAW_W - 1:0] acc,
    output logic                 hit
);

    localparam int IDX_W = (MAX_POPULATION > 1) ? $clog2(MAX_POPULATION) : 1;
    localparam int ACC_W = FITNESS_BITS + IDX_W + DRAW_W;

    logic [ACC_W-1:0] acc_reg;
    logic [ACC_W-1:0] acc_next;
    logic [ACC_W-1:0] addend;

    // Roulette pass works on prefix * scale so the draw threshold needs no divide
    assign addend   = ctl.scaled ? (ACC_W'(fit) * ACC_W'(DRAW_SCALE)) : ACC_W'(fit);
    assign acc_next = acc_reg + addend;
    assign hit      = acc_next > limit;
    assign acc      = acc_reg;

    always_ff @(posedge clk)
    begin
        if (ctl.clr)
        begin
            acc_reg <= '0;
        end
        else if (ctl.en)
        begin
            acc_reg <= acc_next;
        end
    end

endmodule

FILE: rtl/moran_process_step_top.sv
// Moran process step: population store, roulette parent selection, per-type counts.
// A step walks the fitness store twice, one entry per cycle, through its single read port.
// One item at a time; the next item is taken while a finished result waits in the output register.
// Reset clears loaded flags, type counts and the next type id; population_size resets to 100.
module moran_process_step_top
    import mps_pkg::*;
#(
    parameter int MAX_POPULATION = MAX_POPULATION_DEF,
    parameter int FITNESS_BITS   = FITNESS_BITS_DEF,
    parameter int MAX_TYPES      = MAX_TYPES_DEF
)(
    input  logic      clk,
    input  logic      rst_n,
    mps_in_if.sink    item,
    mps_out_if.source result,
    mps_cfg_if.sink   cfg
);

    localparam int IDX_W   = (MAX_POPULATION > 1) ? $clog2(MAX_POPULATION) : 1;
    localparam int TYPE_W  = $clog2(MAX_TYPES);
    localparam int NT_W    = $clog2(MAX_TYPES + 1);
    localparam int CW      = $clog2(MAX_POPULATION + 1);
    localparam int SUM_W   = FITNESS_BITS + IDX_W;
    localparam int ACC_W   = SUM_W + DRAW_W;
    localparam int POP_CAP = (MAX_POPULATION > 255) ? 255 : MAX_POPULATION;
    localparam int CMP_W   = (CW > POP_SIZE_W) ? CW : POP_SIZE_W;

    typedef enum logic [8:0] {
        S_IDLE    = 9'b000000001,
        S_SUM     = 9'b000000010,
        S_SEL     = 9'b000000100,
        S_RD_OLD  = 9'b000001000,
        S_OLD_CNT = 9'b000010000,
        S_DEC     = 9'b000100000,
        S_NEW_CNT = 9'b001000000,
        S_INC     = 9'b010000000,
        S_RESULT  = 9'b100000000
    } state_t;

    typedef struct packed {
        logic [STATUS_W-1:0]  status;
        logic [ENTRY_W-1:0]   victim;
        logic [ENTRY_W-1:0]   parent;
        logic                 mutated;
        logic [TYPE_IN_W-1:0] wtype;
        logic [CNT_OUT_W-1:0] wcount;
        logic                 fixed;
    } res_t;

    // control state
    state_t                    state_reg, state_next;
    logic [POP_SIZE_W-1:0]     pop_size_reg;
    logic [MAX_POPULATION-1:0] loaded_reg;
    logic [MAX_TYPES-1:0]      cnt_vld_reg;
    logic [NT_W-1:0]           next_id_reg, next_id_next;
    logic                      pv_reg, pv_next;
    logic                      out_valid_reg, out_valid_next;

    // datapath registers
    logic [IDX_W-1:0]          vic_reg, vic_next;
    logic [FITNESS_BITS-1:0]   fin_reg, fin_next;
    logic [DRAW_W-1:0]         bd_reg, bd_next;
    logic                      mut_reg, mut_next;
    logic [FITNESS_BITS-1:0]   new_fit_reg, new_fit_next;
    logic [TYPE_W-1:0]         new_typ_reg, new_typ_next;
    logic [TYPE_W-1:0]         old_typ_reg, old_typ_next;
    logic                      old_ld_reg, old_ld_next;
    logic [POP_SIZE_W-1:0]     iss_reg, iss_next;
    logic [POP_SIZE_W-1:0]     pidx_reg, pidx_next;
    logic [ACC_W-1:0]          prod_reg, prod_next;
    res_t                      res_reg, res_next;
    res_t                      out_reg;

    // memories and their read registers
    logic [FITNESS_BITS-1:0]   fit_mem [MAX_POPULATION];
    logic [TYPE_W-1:0]         typ_mem [MAX_POPULATION];
    logic [CW-1:0]             cnt_mem [MAX_TYPES];
    logic [FITNESS_BITS-1:0]   rd_fit_reg;
    logic [TYPE_W-1:0]         rd_typ_reg;
    logic                      rd_ld_reg;
    logic [CW-1:0]             rd_cnt_reg;
    logic                      rd_cnt_ok_reg;

    logic [IDX_W-1:0]          ent_ra;
    logic                      ent_we;
    logic [TYPE_W-1:0]         cnt_ra;
    logic [TYPE_W-1:0]         cnt_wa;
    logic                      cnt_we;
    logic [CW-1:0]             cnt_wd;
    logic                      clear_all;
    logic                      out_load;

    logic [POP_SIZE_W-1:0]     eff_size;
    logic                      walk_issue;
    logic [CW-1:0]             cnt_rd;
    logic [CW-1:0]             cnt_inc;
    logic [SUM_W-1:0]          fit_sum;
    walk_ctl_t                 wk_ctl;
    logic [FITNESS_BITS-1:0]   wk_fit;
    logic [ACC_W-1:0]          wk_acc;
    logic                      wk_hit;

    assign eff_size   = (pop_size_reg > POP_SIZE_W'(POP_CAP)) ? POP_SIZE_W'(POP_CAP)
                                                             : pop_size_reg;
    assign walk_issue = (iss_reg != eff_size);
    assign cnt_rd     = rd_cnt_ok_reg ? rd_cnt_reg : '0;
    assign cnt_inc    = cnt_rd + CW'(1);
    assign fit_sum    = SUM_W'(wk_acc);
    assign wk_fit     = rd_ld_reg ? rd_fit_reg : '0;

    mps_walk #(
        .MAX_POPULATION (MAX_POPULATION),
        .FITNESS_BITS   (FITNESS_BITS)
    ) u_mps_walk (
        .clk   (clk),
        .ctl   (wk_ctl),
        .fit   (wk_fit),
        .limit (prod_reg),
        .acc   (wk_acc),
        .hit   (wk_hit)
    );

    assign item.ready = (state_reg == S_IDLE);
    assign cfg.ready  = 1'b1;

    assign result.valid              = out_valid_reg;
    assign result.status             = out_reg.status;
    assign result.victim_index       = out_reg.victim;
    assign result.parent_index       = out_reg.parent;
    assign result.mutated            = out_reg.mutated;
    assign result.written_type       = out_reg.wtype;
    assign result.written_type_count = out_reg.wcount;
    assign result.fixed              = out_reg.fixed;

    always_comb
    begin
        state_next   = state_reg;
        next_id_next = next_id_reg;
        pv_next      = 1'b0;
        vic_next     = vic_reg;
        fin_next     = fin_reg;
        bd_next      = bd_reg;
        mut_next     = mut_reg;
        new_fit_next = new_fit_reg;
        new_typ_next = new_typ_reg;
        old_typ_next = old_typ_reg;
        old_ld_next  = old_ld_reg;
        iss_next     = iss_reg;
        pidx_next    = pidx_reg;
        prod_next    = prod_reg;
        res_next     = res_reg;
        wk_ctl       = '0;
        ent_ra       = IDX_W'(iss_reg);
        ent_we       = 1'b0;
        cnt_ra       = new_typ_reg;
        cnt_wa       = new_typ_reg;
        cnt_we       = 1'b0;
        cnt_wd       = cnt_inc;
        clear_all    = 1'b0;
        out_load     = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (item.valid)
                begin
                    res_next = '0;
                    vic_next = IDX_W'(item.entry_index);
                    fin_next = FITNESS_BITS'(item.fitness_value);
                    bd_next  = (item.birth_draw > DRAW_MAX) ? DRAW_MAX : item.birth_draw;
                    mut_next = (item.mutation_draw == '0);
                    state_next = S_RESULT;
                    case (item.operation)
                        OP_CLEAR:
                        begin
                            clear_all    = 1'b1;
                            next_id_next = '0;
                        end
                        OP_LOAD:
                        begin
                            res_next.victim = item.entry_index;
                            if (POP_SIZE_W'(item.entry_index) >= eff_size)
                            begin
                                res_next.status = ST_BAD_INDEX;
                            end
                            else if (int'(item.type_value) >= MAX_TYPES)
                            begin
                                res_next.status = ST_NO_TYPE_ID;
                            end
                            else
                            begin
                                new_fit_next = FITNESS_BITS'(item.fitness_value);
                                new_typ_next = TYPE_W'(item.type_value);
                                if (int'(next_id_reg) < int'(item.type_value) + 1)
                                begin
                                    next_id_next = NT_W'(int'(item.type_value) + 1);
                                end
                                state_next = S_RD_OLD;
                            end
                        end
                        OP_STEP:
                        begin
                            res_next.victim = item.entry_index;
                            if (POP_SIZE_W'(item.entry_index) >= eff_size)
                            begin
                                res_next.status = ST_BAD_INDEX;
                            end
                            else
                            begin
                                wk_ctl.clr = 1'b1;
                                iss_next   = '0;
                                state_next = S_SUM;
                            end
                        end
                        default:
                        begin
                            // unused code: all-zero result, nothing changes
                        end
                    endcase
                end
            end

            S_SUM:
            begin
                wk_ctl.en = pv_reg;
                if (!pv_reg && !walk_issue)
                begin
                    if (fit_sum == '0)
                    begin
                        res_next.status = ST_ZERO_FITNESS;
                        state_next      = S_RESULT;
                    end
                    else if (mut_reg && (next_id_reg >= NT_W'(MAX_TYPES)))
                    begin
                        res_next.status = ST_NO_TYPE_ID;
                        state_next      = S_RESULT;
                    end
                    else
                    begin
                        prod_next  = ACC_W'(bd_reg) * ACC_W'(fit_sum);
                        wk_ctl.clr = 1'b1;
                        iss_next   = '0;
                        if (mut_reg)
                        begin
                            new_fit_next     = fin_reg;
                            new_typ_next     = TYPE_W'(next_id_reg);
                            next_id_next     = next_id_reg + NT_W'(1);
                            res_next.mutated = 1'b1;
                        end
                        state_next = S_SEL;
                    end
                end
                else if (walk_issue)
                begin
                    iss_next  = iss_reg + POP_SIZE_W'(1);
                    pidx_next = iss_reg;
                    pv_next   = 1'b1;
                end
            end

            S_SEL:
            begin
                wk_ctl.en     = pv_reg;
                wk_ctl.scaled = 1'b1;
                if (pv_reg && wk_hit)
                begin
                    res_next.parent = ENTRY_W'(pidx_reg);
                    if (!mut_reg)
                    begin
                        new_fit_next = rd_fit_reg;
                        new_typ_next = rd_typ_reg;
                    end
                    state_next = S_RD_OLD;
                end
                else if (walk_issue)
                begin
                    iss_next  = iss_reg + POP_SIZE_W'(1);
                    pidx_next = iss_reg;
                    pv_next   = 1'b1;
                end
                else if (!pv_reg)
                begin
                    state_next = S_RD_OLD;
                end
            end

            S_RD_OLD:
            begin
                ent_ra     = vic_reg;
                state_next = S_OLD_CNT;
            end

            S_OLD_CNT:
            begin
                old_ld_next  = rd_ld_reg;
                old_typ_next = rd_typ_reg;
                cnt_ra       = rd_typ_reg;
                state_next   = S_DEC;
            end

            S_DEC:
            begin
                // drop the old occupant from its type count, then place the newborn
                ent_we = 1'b1;
                if (old_ld_reg && (cnt_rd != '0))
                begin
                    cnt_we = 1'b1;
                    cnt_wa = old_typ_reg;
                    cnt_wd = cnt_rd - CW'(1);
                end
                state_next = S_NEW_CNT;
            end

            S_NEW_CNT:
            begin
                cnt_ra     = new_typ_reg;
                state_next = S_INC;
            end

            S_INC:
            begin
                cnt_we          = 1'b1;
                res_next.wtype  = TYPE_IN_W'(new_typ_reg);
                res_next.wcount = CNT_OUT_W'(cnt_inc);
                res_next.fixed  = (CMP_W'(cnt_inc) == CMP_W'(eff_size));
                state_next      = S_RESULT;
            end

            S_RESULT:
            begin
                if (!out_valid_reg || result.ready)
                begin
                    out_load   = 1'b1;
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        out_valid_next = out_load ? 1'b1 : (out_valid_reg && !result.ready);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            pop_size_reg  <= POP_SIZE_RESET;
            loaded_reg    <= '0;
            cnt_vld_reg   <= '0;
            next_id_reg   <= '0;
            pv_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            next_id_reg   <= next_id_next;
            pv_reg        <= pv_next;
            out_valid_reg <= out_valid_next;
            if (cfg.valid)
            begin
                pop_size_reg <= cfg.population_size;
            end
            if (clear_all)
            begin
                loaded_reg  <= '0;
                cnt_vld_reg <= '0;
            end
            else
            begin
                if (ent_we)
                begin
                    loaded_reg[vic_reg] <= 1'b1;
                end
                if (cnt_we)
                begin
                    cnt_vld_reg[cnt_wa] <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ent_we)
        begin
            fit_mem[vic_reg] <= new_fit_reg;
            typ_mem[vic_reg] <= new_typ_reg;
        end
        rd_fit_reg <= fit_mem[ent_ra];
        rd_typ_reg <= typ_mem[ent_ra];
        rd_ld_reg  <= loaded_reg[ent_ra];

        if (cnt_we)
        begin
            cnt_mem[cnt_wa] <= cnt_wd;
        end
        rd_cnt_reg    <= cnt_mem[cnt_ra];
        rd_cnt_ok_reg <= cnt_vld_reg[cnt_ra];

        vic_reg     <= vic_next;
        fin_reg     <= fin_next;
        bd_reg      <= bd_next;
        mut_reg     <= mut_next;
        new_fit_reg <= new_fit_next;
        new_typ_reg <= new_typ_next;
        old_typ_reg <= old_typ_next;
        old_ld_reg  <= old_ld_next;
        iss_reg     <= iss_next;
        pidx_reg    <= pidx_next;
        prod_reg    <= prod_next;
        res_reg     <= res_next;
        if (out_load)
        begin
            out_reg <= res_reg;
        end
    end

endmodule

FILE: rtl/mps_checker.sv
// Port-level checks for the Moran process step block, bound to the top level.
module mps_checker
    import mps_pkg::*;
(
    input logic                 clk,
    input logic                 rst_n,
    input logic                 item_valid,
    input logic                 item_ready,
    input logic                 out_valid,
    input logic                 out_ready,
    input logic [STATUS_W-1:0]  status,
    input logic [ENTRY_W-1:0]   victim_index,
    input logic [ENTRY_W-1:0]   parent_index,
    input logic                 mutated,
    input logic [TYPE_IN_W-1:0] written_type,
    input logic [CNT_OUT_W-1:0] written_type_count,
    input logic                 fixed
);

    // error results carry only status and victim
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status != ST_OK) |->
            (parent_index == '0) && !mutated && (written_type == '0) &&
            (written_type_count == '0) && !fixed)
    else $error("error result carries nonzero payload");

    // one transaction at a time: input closes right after an accept
    assert property (@(posedge clk) disable iff (!rst_n)
        item_valid && item_ready |=> !item_ready)
    else $error("input accepted while previous transaction in progress");

    // fixation means a successful write of a nonempty type
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && fixed |-> (status == ST_OK) && (written_type_count != '0))
    else $error("fixed reported with empty count or error status");

    // a mutant only comes from a successful step
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && mutated |-> (status == ST_OK))
    else $error("mutant reported on error result");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid &&
            $stable({status, victim_index, parent_index, mutated, written_type,
                     written_type_count, fixed}))
    else $error("stalled result dropped or changed");

endmodule

bind moran_process_step_top mps_checker u_mps_checker (
    .clk                (clk),
    .rst_n              (rst_n),
    .item_valid         (item.valid),
    .item_ready         (item.ready),
    .out_valid          (result.valid),
    .out_ready          (result.ready),
    .status             (result.status),
    .victim_index       (result.victim_index),
    .parent_index       (result.parent_index),
    .mutated            (result.mutated),
    .written_type       (result.written_type),
    .written_type_count (result.written_type_count),
    .fixed              (result.fixed)
);

FILE: dv/moran_process_step_top_tb.sv
// Self-checking testbench for the Moran process step block: directed table, then random phases.
`timescale 1ns / 1ps

module moran_process_step_top_tb;
    import mps_pkg::*;

    localparam int MAX_POP     = MAX_POPULATION_DEF;
    localparam int MAX_KINDS   = MAX_TYPES_DEF;
    localparam int FIT_MASK    = (1 << FITNESS_BITS_DEF) - 1;
    localparam int N_PHASES    = 9;
    localparam int END_DRAIN   = 300;
    localparam int CFG_SETTLE  = 8;
    localparam longint TIMEOUT_NS = 15_000_000;

    // The block defines no behavior for this code beyond an all-zero result.
    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

    typedef struct packed {
        logic [OP_W-1:0]      operation;
        logic [ENTRY_W-1:0]   entry_index;
        logic [FIT_IN_W-1:0]  fitness_value;
        logic [TYPE_IN_W-1:0] type_value;
        logic [DRAW_W-1:0]    birth_draw;
        logic [DRAW_W-1:0]    mutation_draw;
    } moran_item_t;

    typedef struct packed {
        logic [STATUS_W-1:0]  status;
        logic [ENTRY_W-1:0]   victim_index;
        logic [ENTRY_W-1:0]   parent_index;
        logic                 mutated;
        logic [TYPE_IN_W-1:0] written_type;
        logic [CNT_OUT_W-1:0] written_type_count;
        logic                 fixed;
    } moran_result_t;

    typedef enum {ROW_ITEM, ROW_CFG} row_kind_t;

    typedef struct {
        row_kind_t       kind;
        moran_item_t     it;
        logic [7:0]      size_value;
        bit              typed;
        moran_result_t   exp;
    } stim_row_t;

    logic clk;
    logic rst_n;

    mps_in_if  in_ch ();
    mps_out_if out_ch ();
    mps_cfg_if cfg_ch ();

    moran_process_step_top dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (in_ch),
        .result (out_ch),
        .cfg    (cfg_ch)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // Predictor state
    int unsigned pop_fit   [MAX_POP];
    int unsigned pop_kind  [MAX_POP];
    bit          pop_live  [MAX_POP];
    int unsigned kind_count[MAX_KINDS];
    int unsigned next_kind;
    logic [7:0]  pop_size_reg;

    // Stimulus-side bookkeeping
    bit          ever_written[MAX_POP];
    int unsigned gen_size;
    logic        typed_now;
    moran_result_t typed_exp;
    moran_result_t expected_outcomes[$];
    stim_row_t   directed_rows[$];
    int          src_quiet;
    int          snk_quiet;

    // Statistics
    int mismatch_count;
    int items_in;
    int results_out;
    int ok_steps;
    int mutants_seen;
    int fixed_seen;
    int status_seen[4];

    function automatic void clear_population();
        for (int i = 0; i < MAX_POP; i++)
        begin
            pop_fit[i]  = 0;
            pop_kind[i] = 0;
            pop_live[i] = 1'b0;
        end
        for (int i = 0; i < MAX_KINDS; i++)
            kind_count[i] = 0;
        next_kind = 0;
    endfunction

    function automatic void drop_entry(int unsigned e);
        if (pop_live[e])
        begin
            if (kind_count[pop_kind[e]] > 0)
                kind_count[pop_kind[e]]--;
            pop_live[e] = 1'b0;
        end
    endfunction

    function automatic void put_entry(int unsigned e, int unsigned fit, int unsigned kind);
        pop_fit[e]  = fit;
        pop_kind[e] = kind % MAX_KINDS;
        pop_live[e] = 1'b1;
        kind_count[kind % MAX_KINDS]++;
    endfunction

    function automatic moran_result_t predict_birth_death(moran_item_t it);
        moran_result_t   r;
        int unsigned     size;
        int unsigned     e;
        int unsigned     cnt;
        int unsigned     pfit;
        int unsigned     ptype;
        int unsigned     parent;
        longint unsigned sum;
        longint unsigned thr;
        longint unsigned prefix;
        longint unsigned draw;
        bit              mut;
        int              i;
        r    = '0;
        size = (pop_size_reg > MAX_POP) ? MAX_POP : pop_size_reg;
        e    = it.entry_index;
        case (it.operation)
            OP_CLEAR:
            begin
                clear_population();
            end
            OP_LOAD:
            begin
                r.victim_index = it.entry_index;
                if (e >= size)
                    r.status = ST_BAD_INDEX;
                else
                begin
                    drop_entry(e);
                    put_entry(e, it.fitness_value & FIT_MASK, it.type_value);
                    if (next_kind < it.type_value + 1)
                        next_kind = it.type_value + 1;
                    cnt = kind_count[it.type_value];
                    r.status             = ST_OK;
                    r.written_type       = it.type_value;
                    r.written_type_count = 8'(cnt);
                    r.fixed              = (cnt == size);
                end
            end
            OP_STEP:
            begin
                r.victim_index = it.entry_index;
                sum = 0;
                mut = (it.mutation_draw == 0);
                if (e < size)
                    for (i = 0; i < size; i++)
                        if (pop_live[i])
                            sum += pop_fit[i];
                if (e >= size)
                    r.status = ST_BAD_INDEX;
                else if (sum == 0)
                    r.status = ST_ZERO_FITNESS;
                else if (mut && next_kind >= MAX_KINDS)
                    r.status = ST_NO_TYPE_ID;
                else
                begin
                    draw   = (it.birth_draw > DRAW_MAX) ? DRAW_MAX : it.birth_draw;
                    thr    = draw * sum / DRAW_SCALE;
                    prefix = 0;
                    parent = 0;
                    // first entry whose running sum passes the threshold wins
                    for (i = 0; i < size; i++)
                    begin
                        if (pop_live[i])
                            prefix += pop_fit[i];
                        if (prefix > thr)
                        begin
                            parent = i;
                            break;
                        end
                    end
                    pfit  = pop_fit[parent];
                    ptype = pop_kind[parent];
                    if (mut)
                    begin
                        pfit  = it.fitness_value & FIT_MASK;
                        ptype = next_kind;
                        next_kind++;
                    end
                    drop_entry(e);
                    put_entry(e, pfit, ptype);
                    cnt = kind_count[ptype % MAX_KINDS];
                    r.status             = ST_OK;
                    r.parent_index       = 7'(parent);
                    r.mutated            = mut;
                    r.written_type       = 8'(ptype);
                    r.written_type_count = 8'(cnt);
                    r.fixed              = (cnt == size);
                end
            end
            default:
            begin
            end
        endcase
        return r;
    endfunction

    function automatic int pick_gap(inout int quiet);
        int r;
        if (quiet > 0)
        begin
            quiet--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 3)
        begin
            quiet = $urandom_range(20, 60);
            return 0;
        end
        if (r < 50)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic stim_row_t item_row(logic [OP_W-1:0] op, int idx, int fit, int typ,
                                           int bd, int md, bit typed = 1'b0,
                                           moran_result_t exp = '0);
        stim_row_t row;
        row.kind       = ROW_ITEM;
        row.it         = '{op, ENTRY_W'(idx), FIT_IN_W'(fit), TYPE_IN_W'(typ),
                           DRAW_W'(bd), DRAW_W'(md)};
        row.size_value = '0;
        row.typed      = typed;
        row.exp        = exp;
        return row;
    endfunction

    function automatic stim_row_t cfg_row(int v);
        stim_row_t row;
        row.kind       = ROW_CFG;
        row.it         = '0;
        row.size_value = 8'(v);
        row.typed      = 1'b0;
        row.exp        = '0;
        return row;
    endfunction

    function automatic void check_field(string fname, logic [7:0] expv, logic [7:0] actv);
        if (actv !== expv)
        begin
            mismatch_count++;
            if (mismatch_count <= 10)
                $display("%0t: mismatch on %s: expected %0d, got %0d", $realtime, fname,
                         expv, actv);
        end
    endfunction

    task automatic send_item(moran_item_t it, bit typed, moran_result_t exp);
        int gap;
        gap = pick_gap(src_quiet);
        if (gap > 0)
        begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_ch.valid         <= 1'b1;
        in_ch.operation     <= it.operation;
        in_ch.entry_index   <= it.entry_index;
        in_ch.fitness_value <= it.fitness_value;
        in_ch.type_value    <= it.type_value;
        in_ch.birth_draw    <= it.birth_draw;
        in_ch.mutation_draw <= it.mutation_draw;
        typed_now           <= typed;
        typed_exp           <= exp;
        if (it.operation == OP_LOAD && it.entry_index < gen_size)
            ever_written[it.entry_index] = 1'b1;
        do @(posedge clk); while (!in_ch.ready);
    endtask

    // Hold the sender until every expected result has been drained.
    task automatic wait_idle(int settle);
        in_ch.valid <= 1'b0;
        @(posedge clk);
        while (expected_outcomes.size() != 0)
            @(posedge clk);
        repeat (settle) @(posedge clk);
    endtask

    task automatic write_config(logic [7:0] v);
        wait_idle(CFG_SETTLE);
        cfg_ch.valid           <= 1'b1;
        cfg_ch.population_size <= v;
        do @(posedge clk); while (!cfg_ch.ready);
        cfg_ch.valid <= 1'b0;
        gen_size = (v > MAX_POP) ? MAX_POP : v;
    endtask

    // Predict on every accepted input transaction
    always @(posedge clk)
    begin : accept_mon
        moran_item_t   seen;
        moran_result_t predicted;
        if (rst_n && in_ch.valid === 1'b1 && in_ch.ready === 1'b1)
        begin
            seen = '{in_ch.operation, in_ch.entry_index, in_ch.fitness_value,
                     in_ch.type_value, in_ch.birth_draw, in_ch.mutation_draw};
            predicted = predict_birth_death(seen);
            expected_outcomes.push_back(typed_now ? typed_exp : predicted);
            items_in++;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && cfg_ch.valid === 1'b1 && cfg_ch.ready === 1'b1)
            pop_size_reg = cfg_ch.population_size;
    end

    // Compare every result transaction with the oldest expectation
    always @(posedge clk)
    begin : result_mon
        moran_result_t exp;
        if (rst_n && out_ch.valid === 1'b1 && out_ch.ready === 1'b1)
        begin
            results_out++;
            if (expected_outcomes.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("%0t: result with nothing expected (status %0d, victim %0d)",
                             $realtime, out_ch.status, out_ch.victim_index);
            end
            else
            begin
                exp = expected_outcomes.pop_front();
                check_field("status", exp.status, out_ch.status);
                check_field("victim_index", exp.victim_index, out_ch.victim_index);
                check_field("parent_index", exp.parent_index, out_ch.parent_index);
                check_field("mutated", exp.mutated, out_ch.mutated);
                check_field("written_type", exp.written_type, out_ch.written_type);
                check_field("written_type_count", exp.written_type_count,
                            out_ch.written_type_count);
                check_field("fixed", exp.fixed, out_ch.fixed);
                status_seen[exp.status]++;
                if (exp.status == ST_OK && exp.mutated)
                    mutants_seen++;
                if (exp.status == ST_OK && exp.fixed)
                    fixed_seen++;
            end
        end
    end

    // Result-side stalls
    initial
    begin : sink_drv
        int gap;
        out_ch.ready <= 1'b0;
        @(posedge clk);
        forever
        begin
            gap = pick_gap(snk_quiet);
            if (gap > 0)
            begin
                out_ch.ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            out_ch.ready <= 1'b1;
            do @(posedge clk); while (out_ch.valid !== 1'b1);
        end
    end

    initial
    begin
        #(TIMEOUT_NS);
        $display("TEST FAILED");
        $finish;
    end

    initial
    begin : main_seq
        logic [7:0]  phase_size [N_PHASES];
        int          phase_items[N_PHASES];
        moran_item_t it;
        int          counted;
        int          r;
        int          hole;

        phase_size  = '{8'd255, 8'd6, 8'd2, 8'd40, 8'd128, 8'd1, 8'd3, 8'd16, 8'd100};
        phase_items = '{40, 90, 90, 60, 30, 40, 90, 90, 70};

        rst_n                  <= 1'b0;
        in_ch.valid            <= 1'b0;
        in_ch.operation        <= OP_CLEAR;
        in_ch.entry_index      <= '0;
        in_ch.fitness_value    <= '0;
        in_ch.type_value       <= '0;
        in_ch.birth_draw       <= '0;
        in_ch.mutation_draw    <= '0;
        cfg_ch.valid           <= 1'b0;
        cfg_ch.population_size <= POP_SIZE_RESET;
        typed_now              <= 1'b0;
        typed_exp              <= '0;
        clear_population();
        pop_size_reg   = POP_SIZE_RESET;
        gen_size       = POP_SIZE_RESET;
        src_quiet      = 0;
        snk_quiet      = 0;
        mismatch_count = 0;
        items_in       = 0;
        results_out    = 0;
        ok_steps       = 0;
        mutants_seen   = 0;
        fixed_seen     = 0;
        foreach (status_seen[k])
            status_seen[k] = 0;
        foreach (ever_written[k])
            ever_written[k] = 1'b0;

        // After reset: unused code, out-of-range indexes, clear
        directed_rows.push_back(item_row(OP_UNUSED, 5, 9, 3, 100, 100, 1'b1, '0));
        directed_rows.push_back(item_row(OP_LOAD, 127, 1023, 255, 16383, 16383, 1'b1,
            '{ST_BAD_INDEX, 7'd127, 7'd0, 1'b0, 8'd0, 8'd0, 1'b0}));
        directed_rows.push_back(item_row(OP_STEP, 100, 7, 0, 5000, 0, 1'b1,
            '{ST_BAD_INDEX, 7'd100, 7'd0, 1'b0, 8'd0, 8'd0, 1'b0}));
        directed_rows.push_back(item_row(OP_CLEAR, 3, 3, 3, 3, 3, 1'b1, '0));
        // Empty population: every index is out of range
        directed_rows.push_back(cfg_row(0));
        directed_rows.push_back(item_row(OP_LOAD, 0, 1, 1, 0, 0, 1'b1,
            '{ST_BAD_INDEX, 7'd0, 7'd0, 1'b0, 8'd0, 8'd0, 1'b0}));
        // Single entry: top type id, saturated draw, id exhaustion, zero fitness
        directed_rows.push_back(cfg_row(1));
        directed_rows.push_back(item_row(OP_LOAD, 0, 1023, 255, 0, 0, 1'b1,
            '{ST_OK, 7'd0, 7'd0, 1'b0, 8'd255, 8'd1, 1'b1}));
        directed_rows.push_back(item_row(OP_STEP, 0, 0, 0, 16383, 1));
        directed_rows.push_back(item_row(OP_STEP, 0, 10, 0, 0, 0, 1'b1,
            '{ST_NO_TYPE_ID, 7'd0, 7'd0, 1'b0, 8'd0, 8'd0, 1'b0}));
        directed_rows.push_back(item_row(OP_STEP, 1, 10, 0, 0, 9999, 1'b1,
            '{ST_BAD_INDEX, 7'd1, 7'd0, 1'b0, 8'd0, 8'd0, 1'b0}));
        directed_rows.push_back(item_row(OP_LOAD, 0, 0, 0, 0, 0));
        directed_rows.push_back(item_row(OP_STEP, 0, 10, 0, 9999, 0, 1'b1,
            '{ST_ZERO_FITNESS, 7'd0, 7'd0, 1'b0, 8'd0, 8'd0, 1'b0}));
        directed_rows.push_back(item_row(OP_CLEAR, 0, 0, 0, 0, 0, 1'b1, '0));
        directed_rows.push_back(item_row(OP_LOAD, 0, 5, 7, 0, 0));
        directed_rows.push_back(item_row(OP_STEP, 0, 1023, 0, 0, 0));
        // Four entries: zero-fitness member, reload, first and last roulette slots
        directed_rows.push_back(cfg_row(4));
        directed_rows.push_back(item_row(OP_LOAD, 1, 0, 2, 0, 0));
        directed_rows.push_back(item_row(OP_LOAD, 2, 1023, 8, 0, 0));
        directed_rows.push_back(item_row(OP_LOAD, 3, 1, 8, 0, 0));
        directed_rows.push_back(item_row(OP_STEP, 3, 0, 0, 0, 9999));
        directed_rows.push_back(item_row(OP_STEP, 1, 0, 0, 9999, 16383));
        directed_rows.push_back(item_row(OP_LOAD, 2, 3, 1, 0, 0));
        directed_rows.push_back(item_row(OP_STEP, 0, 512, 0, 5000, 0));
        directed_rows.push_back(item_row(OP_CLEAR, 0, 0, 0, 0, 0, 1'b1, '0));
        directed_rows.push_back(item_row(OP_STEP, 2, 0, 0, 1, 1, 1'b1,
            '{ST_ZERO_FITNESS, 7'd2, 7'd0, 1'b0, 8'd0, 8'd0, 1'b0}));

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[k])
        begin
            if (directed_rows[k].kind == ROW_CFG)
                write_config(directed_rows[k].size_value);
            else
                send_item(directed_rows[k].it, directed_rows[k].typed, directed_rows[k].exp);
        end

        for (int p = 0; p < N_PHASES; p++)
        begin
            write_config(phase_size[p]);
            counted = 0;
            while (counted < phase_items[p])
            begin
                it = '0;
                r  = $urandom_range(0, 99);
                if (r < 2)
                    it.operation = OP_UNUSED;
                else if (r < 5)
                    it.operation = OP_CLEAR;
                else if (r < 40)
                    it.operation = OP_LOAD;
                else
                    it.operation = OP_STEP;
                it.entry_index = ENTRY_W'(($urandom_range(0, 99) < 7 || gen_size == 0) ?
                                          $urandom_range(0, MAX_POP - 1) :
                                          $urandom_range(0, gen_size - 1));
                r = $urandom_range(0, 99);
                it.fitness_value = FIT_IN_W'((r < 10) ? 0 : (r < 20) ? FIT_MASK :
                                             (r < 50) ? $urandom_range(1, 15) :
                                             $urandom_range(0, FIT_MASK));
                it.type_value = TYPE_IN_W'(($urandom_range(0, 99) < 4) ?
                                           $urandom_range(0, 255) : $urandom_range(0, 7));
                r = $urandom_range(0, 99);
                it.birth_draw = DRAW_W'((r < 5) ? 0 :
                                        (r < 10) ? $urandom_range(10000, 16383) :
                                        $urandom_range(0, 9999));
                r = $urandom_range(0, 99);
                it.mutation_draw = DRAW_W'((r < 12) ? 0 :
                                           (r < 15) ? $urandom_range(10000, 16383) :
                                           $urandom_range(1, 9999));
                // Steps walk every entry in use: write any never-written one first
                if (it.operation == OP_STEP)
                begin
                    hole = -1;
                    for (int i = 0; i < gen_size; i++)
                        if (!ever_written[i] && hole < 0)
                            hole = i;
                    if (hole >= 0)
                    begin
                        it.operation   = OP_LOAD;
                        it.entry_index = ENTRY_W'(hole);
                        it.type_value  = TYPE_IN_W'($urandom_range(0, 7));
                    end
                end
                send_item(it, 1'b0, '0);
                if (it.operation != OP_UNUSED)
                    counted++;
                if ($urandom_range(0, 99) < 3)
                    wait_idle(0);
            end
        end

        wait_idle(END_DRAIN);
        ok_steps = status_seen[ST_OK];
        $display("Covered %0d input and %0d result transactions over %0d size settings;",
                 items_in, results_out, N_PHASES + 4);
        $display("ok %0d, bad idx %0d, zero fit %0d, no id %0d, mutants %0d, fixed %0d",
                 ok_steps, status_seen[ST_BAD_INDEX], status_seen[ST_ZERO_FITNESS],
                 status_seen[ST_NO_TYPE_ID], mutants_seen, fixed_seen);
        if (mismatch_count == 0 && expected_outcomes.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
